>>> sv/cwe_pkg.sv
package cwe_pkg;

   // field widths fixed by the interface
   localparam int CRC_W      = 32;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = 64;
   localparam int CNT_W      = 4;
   localparam int MAX_BYTES  = 8;

   // reflected castagnoli polynomial
   localparam logic [CRC_W-1:0] CRC_POLY = 32'h82F6_3B78;

   // column images of the byte-shift map raised to each power 0..MAX_BYTES
   typedef logic [MAX_BYTES:0][CRC_W-1:0][CRC_W-1:0] col_tbl_type;

   // stage-one control and payload handed to the merge stage
   typedef struct packed {
      logic             valid;
      logic             start;
      logic             last;
      logic [CRC_W-1:0] seed;
      logic [CNT_W-1:0] count;
   } s1_ctrl_type;

   // builds the shift matrices bit by bit, elaboration only
   function automatic col_tbl_type build_cols();
      col_tbl_type      tbl;
      logic [CRC_W-1:0] v;
      tbl = '0;
      for (int k = 0; k <= MAX_BYTES; k++) begin
         for (int j = 0; j < CRC_W; j++) begin
            v = CRC_W'(1) << j;
            for (int s = 0; s < BYTE_W * k; s++) begin
               v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
            end
            tbl[k][j] = v;
         end
      end
      return tbl;
   endfunction

   localparam col_tbl_type SHIFT_COL = build_cols();

   // advances a crc state by k zero bytes as one xor matrix
   function automatic logic [CRC_W-1:0] shift_bytes(input logic [CRC_W-1:0] v,
                                                    input logic [CNT_W-1:0] k);
      logic [CRC_W-1:0] r;
      r = '0;
      for (int j = 0; j < CRC_W; j++) begin
         if (v[j]) begin
            r = r ^ SHIFT_COL[k][j];
         end
      end
      return r;
   endfunction

endpackage

>>> sv/cwe_lane.sv
module cwe_lane #(
   parameter int LANE           = 0,
   parameter int BYTES_PER_ITEM = cwe_pkg::MAX_BYTES
) (
   input  logic                       clock,
   input  logic                       load,
   input  logic [cwe_pkg::CNT_W-1:0]  count,
   input  logic [cwe_pkg::BYTE_W-1:0] data_byte,
   output logic [cwe_pkg::CRC_W-1:0]  contrib
);
   import cwe_pkg::*;

   logic [CRC_W-1:0] contrib_in;
   logic [CRC_W-1:0] contrib_ff;

   // byte pushed through the bytes that follow it in this transaction
   always_comb begin
      contrib_in = '0;
      for (int k = 1; k <= BYTES_PER_ITEM - LANE; k++) begin
         if (count == CNT_W'(LANE + k)) begin
            contrib_in = shift_bytes({{(CRC_W-BYTE_W){1'b0}}, data_byte}, CNT_W'(k));
         end
      end
   end

   // lane result register
   always_ff @(posedge clock) begin
      if (load) begin
         contrib_ff <= contrib_in;
      end
   end

   assign contrib = contrib_ff;

endmodule

>>> sv/cwe_merge.sv
module cwe_merge #(
   parameter int BYTES_PER_ITEM = cwe_pkg::MAX_BYTES
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  cwe_pkg::s1_ctrl_type                          s1_ctrl,
   input  logic [BYTES_PER_ITEM-1:0][cwe_pkg::CRC_W-1:0] lane_contrib,
   output logic                                          s1_advance,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic [cwe_pkg::CRC_W-1:0]                     rsp_crc_value
);
   import cwe_pkg::*;

   localparam int IDX_W = $clog2(BYTES_PER_ITEM + 1);

   logic [CRC_W-1:0] crc_base;
   logic [CRC_W-1:0] data_sum;
   logic [CRC_W-1:0] shifted [0:BYTES_PER_ITEM];
   logic [CRC_W-1:0] crc_next;
   logic             out_free;
   logic             load_out;
   logic [CRC_W-1:0] running_crc_ff;
   logic [CRC_W-1:0] running_crc_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic [CRC_W-1:0] rsp_crc_ff;

   // combine lane contributions with the shifted running state
   always_comb begin
      crc_base = s1_ctrl.start ? s1_ctrl.seed : running_crc_ff;
      data_sum = '0;
      for (int i = 0; i < BYTES_PER_ITEM; i++) begin
         data_sum = data_sum ^ lane_contrib[i];
      end
      for (int k = 0; k <= BYTES_PER_ITEM; k++) begin
         shifted[k] = shift_bytes(crc_base, CNT_W'(k));
      end
      crc_next = shifted[s1_ctrl.count[IDX_W-1:0]] ^ data_sum;
   end

   // stage advance and output register control
   always_comb begin
      out_free       = !rsp_valid_ff || !rsp_stall;
      s1_advance     = s1_ctrl.valid && (!s1_ctrl.last || out_free);
      load_out       = s1_advance && s1_ctrl.last;
      running_crc_in = s1_advance ? crc_next : running_crc_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   // running state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         running_crc_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_crc_ff <= crc_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

endmodule

>>> sv/crc32c_word_engine.sv
// crc32c word engine: reflected castagnoli crc over little-endian 64-bit words
//
// request channel (req_*): one transaction per word, byte 0 in bits 7:0 first,
// req_byte_count valid bytes (counts above BYTES_PER_ITEM saturate). with
// req_start_req set the seed replaces the running crc before the word folds in.
// no inversion is applied at either end.
// response channel (rsp_*): one transaction per word flagged req_last, carrying
// the running crc after that word. the running crc is kept after the response.
// throughput: one word per clock while no last word waits in stage one.
// each byte lane folds its byte in stage one; the merge stage applies the
// running crc update, which is the only loop in the design and sets the
// one-word-per-clock rate. a last word's crc is registered after stage one.
// stall: a stalled response holds; words without last keep flowing, and a
// second last word waits in stage one, stalling the request side, until the
// output register frees.
// reset: synchronous; clears the running crc to zero and empties both stages.
module crc32c_word_engine #(
   parameter int BYTES_PER_ITEM = cwe_pkg::MAX_BYTES
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_start_req,
   input  logic [cwe_pkg::CRC_W-1:0]  req_seed,
   input  logic [cwe_pkg::WORD_W-1:0] req_data_word,
   input  logic [cwe_pkg::CNT_W-1:0]  req_byte_count,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [cwe_pkg::CRC_W-1:0]  rsp_crc_value
);
   import cwe_pkg::*;

   logic                                 accept;
   logic                                 s1_advance;
   logic [CNT_W-1:0]                     count_sat;
   s1_ctrl_type                          s1_ctrl_ff;
   s1_ctrl_type                          s1_ctrl_in;
   logic [BYTES_PER_ITEM-1:0][CRC_W-1:0] lane_contrib;

   // request handshake
   assign req_stall = s1_ctrl_ff.valid && !s1_advance;
   assign accept    = req_valid && !req_stall;

   // clamp byte count to the lane count
   assign count_sat = (req_byte_count > CNT_W'(BYTES_PER_ITEM)) ?
                      CNT_W'(BYTES_PER_ITEM) : req_byte_count;

   // stage-one control next value
   always_comb begin
      s1_ctrl_in = s1_ctrl_ff;
      if (accept) begin
         s1_ctrl_in.valid = 1'b1;
         s1_ctrl_in.start = req_start_req;
         s1_ctrl_in.last  = req_last;
         s1_ctrl_in.seed  = req_seed;
         s1_ctrl_in.count = count_sat;
      end else if (s1_advance) begin
         s1_ctrl_in.valid = 1'b0;
      end
   end

   // stage-one control register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff.valid <= 1'b0;
      end else begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   // one fold lane per byte
   for (genvar i = 0; i < BYTES_PER_ITEM; i++) begin : g_lane
      cwe_lane #(
         .LANE           (i),
         .BYTES_PER_ITEM (BYTES_PER_ITEM)
      ) u_lane (
         .clock     (clock),
         .load      (accept),
         .count     (count_sat),
         .data_byte (req_data_word[BYTE_W*i +: BYTE_W]),
         .contrib   (lane_contrib[i])
      );
   end

   // merge lanes into the running crc
   cwe_merge #(
      .BYTES_PER_ITEM (BYTES_PER_ITEM)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .s1_ctrl       (s1_ctrl_ff),
      .lane_contrib  (lane_contrib),
      .s1_advance    (s1_advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_crc_value (rsp_crc_value)
   );

endmodule

>>> sv/cwe_checker.sv
module cwe_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      req_last,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [cwe_pkg::CRC_W-1:0] rsp_crc_value
);

   // stalled response stays valid
   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // stalled response payload holds
   a_rsp_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_crc_value))
      else $error("response payload changed while stalled");

   // request side stalls only behind a stalled response
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a blocked response");

   // a fresh response follows an accepted last transaction
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_last, 2))
      else $error("response without a preceding last transaction");

endmodule

bind crc32c_word_engine cwe_checker u_cwe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_last      (req_last),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_crc_value (rsp_crc_value)
);

>>> test/crc32c_word_checker.sv
`timescale 1ns / 100ps

module crc32c_word_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_start_req,
   input  logic [cwe_pkg::CRC_W-1:0]  req_seed,
   input  logic [cwe_pkg::WORD_W-1:0] req_data_word,
   input  logic [cwe_pkg::CNT_W-1:0]  req_byte_count,
   input  logic                       req_last,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [cwe_pkg::CRC_W-1:0]  rsp_crc_value,
   output int                         mismatch_count,
   output int                         crc_outstanding,
   output int                         crc_checked
);

   // running crc as the block should hold it, and crcs still owed on the response side
   logic [cwe_pkg::CRC_W-1:0] crc_state;
   logic [cwe_pkg::CRC_W-1:0] owed_crc[$];
   int                        errors;
   int                        matched;

   // one byte through the reflected castagnoli lfsr, lsb first
   function automatic logic [cwe_pkg::CRC_W-1:0] castagnoli_byte(
      input logic [cwe_pkg::CRC_W-1:0] crc_in,
      input logic [7:0]                data_byte
   );
      logic [cwe_pkg::CRC_W-1:0] c;
      c = crc_in ^ {24'h0, data_byte};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ cwe_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   // fold the valid low bytes of one word, counts above eight saturate
   function automatic logic [cwe_pkg::CRC_W-1:0] castagnoli_word(
      input logic [cwe_pkg::CRC_W-1:0]  crc_in,
      input logic [cwe_pkg::WORD_W-1:0] word,
      input logic [cwe_pkg::CNT_W-1:0]  count
   );
      logic [cwe_pkg::CRC_W-1:0] c;
      int                        n;
      c = crc_in;
      n = (count > cwe_pkg::MAX_BYTES) ? cwe_pkg::MAX_BYTES : int'(count);
      for (int i = 0; i < n; i++) begin
         c = castagnoli_byte(c, word[8*i +: 8]);
      end
      return c;
   endfunction

   // watch both channels; responses are compared before the word of the same edge
   always @(posedge clock) begin : watch
      logic [cwe_pkg::CRC_W-1:0] want;
      if (reset) begin
         crc_state = '0;
         owed_crc.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_crc.size() == 0) begin
               $display("%0t: unexpected crc transaction, expected none, actual %08h",
                        $time, rsp_crc_value);
               errors++;
            end else begin
               want = owed_crc.pop_front();
               matched++;
               if (rsp_crc_value !== want) begin
                  $display("%0t: crc_value mismatch, expected %08h, actual %08h",
                           $time, want, rsp_crc_value);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            crc_state = castagnoli_word(req_start_req ? req_seed : crc_state,
                                        req_data_word, req_byte_count);
            if (req_last) begin
               owed_crc.push_back(crc_state);
            end
         end
      end
      mismatch_count  <= errors;
      crc_outstanding <= owed_crc.size();
      crc_checked     <= matched;
   end

endmodule

>>> test/crc32c_word_engine_tb.sv
`timescale 1ns / 100ps

module crc32c_word_engine_tb;

   localparam int TARGET_WORDS = 1370;
   localparam int HOLD_CYCLES  = 60;
   localparam int QUIET_LIMIT  = 2000;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       req_valid      = 1'b0;
   logic                       req_stall;
   logic                       req_start_req  = 1'b0;
   logic [cwe_pkg::CRC_W-1:0]  req_seed       = '0;
   logic [cwe_pkg::WORD_W-1:0] req_data_word  = '0;
   logic [cwe_pkg::CNT_W-1:0]  req_byte_count = '0;
   logic                       req_last       = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall      = 1'b0;
   logic [cwe_pkg::CRC_W-1:0]  rsp_crc_value;

   int mismatch_count;
   int crc_outstanding;
   int crc_checked;
   int words_sent  = 0;
   bit tx_idle_on  = 1'b1;
   bit rx_idle_on  = 1'b1;
   int hold_token  = 0;
   int hold_seen   = 0;
   int hold_left   = 0;

   always #4 clock = ~clock;

   crc32c_word_engine dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_req  (req_start_req),
      .req_seed       (req_seed),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_crc_value  (rsp_crc_value)
   );

   crc32c_word_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_start_req   (req_start_req),
      .req_seed        (req_seed),
      .req_data_word   (req_data_word),
      .req_byte_count  (req_byte_count),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_crc_value   (rsp_crc_value),
      .mismatch_count  (mismatch_count),
      .crc_outstanding (crc_outstanding),
      .crc_checked     (crc_checked)
   );

   // response side: random stalls, plus a long hold-off whenever the token moves
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_seen != hold_token) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= rx_idle_on && ($urandom_range(99) < 6);
      end
   end

   // offer one word and wait until it is taken
   task automatic send_word(input bit                        seeded,
                            input logic [cwe_pkg::CRC_W-1:0]  seed,
                            input logic [cwe_pkg::WORD_W-1:0] word,
                            input logic [cwe_pkg::CNT_W-1:0]  count,
                            input bit                        msg_end);
      while (tx_idle_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_req  <= seeded;
      req_seed       <= seed;
      req_data_word  <= word;
      req_byte_count <= count;
      req_last       <= msg_end;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      words_sent++;
   endtask

   // stop offering and wait for every owed crc to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (crc_outstanding != 0);
   endtask

   // watchdog on transaction progress
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: watchdog, no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int         len;
      int         r;
      bit         held;
      bit         paused;
      logic [3:0] cnt;
      held   = 1'b0;
      paused = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // no seed right after reset: folds from zero
      send_word(1'b0, 32'h0, 64'h0, 4'd8, 1'b1);
      // standard check string 123456789 across two words
      send_word(1'b1, 32'hFFFF_FFFF, 64'h3837_3635_3433_3231, 4'd8, 1'b0);
      send_word(1'b0, 32'h0, 64'h0000_0000_0000_0039, 4'd1, 1'b1);
      // zero byte count, with and without a seed load
      send_word(1'b1, 32'hDEAD_BEEF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1);
      send_word(1'b0, 32'h1234_5678, 64'h5A5A_5A5A_5A5A_5A5A, 4'd0, 1'b1);
      // counts above eight saturate
      send_word(1'b1, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9, 1'b1);
      send_word(1'b1, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
      // garbage above the byte count is ignored
      send_word(1'b1, 32'hFFFF_FFFF, 64'hA5A5_A5A5_A512_3456, 4'd3, 1'b1);
      // message without a seed continues from the previous crc
      send_word(1'b0, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF, 4'd8, 1'b0);
      send_word(1'b0, 32'h0, 64'hFEDC_BA98_7654_3210, 4'd4, 1'b1);
      // every count from one to eight in one message
      for (int k = 1; k <= 8; k++) begin
         send_word(k == 1, 32'hFFFF_FFFF ^ k, {$urandom, $urandom}, 4'(k), k == 8);
      end
      // seed reload in the middle of a message
      send_word(1'b1, 32'h0, {$urandom, $urandom}, 4'd8, 1'b0);
      send_word(1'b1, 32'hFFFF_FFFF, {$urandom, $urandom}, 4'd5, 1'b1);
      wait_drained();

      // random messages of one to six words
      while (words_sent < TARGET_WORDS) begin
         // quiet stretch with no idling on either side
         tx_idle_on = !(words_sent >= 300 && words_sent < 550);
         rx_idle_on <= tx_idle_on;

         // response hold-off while single-word messages keep coming
         if (!held && words_sent >= 800) begin
            held = 1'b1;
            hold_token <= hold_token + 1;
            repeat (14) begin
               send_word(1'b1, $urandom, {$urandom, $urandom},
                         4'($urandom_range(1, 8)), 1'b1);
            end
         end

         // sender pause until every crc has returned
         if (!paused && words_sent >= 1100) begin
            paused = 1'b1;
            wait_drained();
         end

         len = $urandom_range(1, 6);
         for (int w = 0; w < len; w++) begin
            r = $urandom_range(99);
            if (r < 84) begin
               cnt = 4'($urandom_range(1, 8));
            end else if (r < 90) begin
               cnt = 4'd0;
            end else begin
               cnt = 4'($urandom_range(9, 15));
            end
            r = $urandom_range(99);
            send_word((w == 0) ? (r < 90) : (r < 4), $urandom, {$urandom, $urandom},
                      cnt, w == len - 1);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("summary: %0d words sent, %0d crc results checked", words_sent, crc_checked);
      $display("summary: byte counts 0 to 15, seeded and chained messages, hold-off and drain");
      if (mismatch_count == 0 && crc_outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
